// ===== rtl/core/sct_pkg.sv =====
// sleep countdown table: shared types and codes
// used by sct_dec_unit and sleep_countdown_table_core; no dependencies
package sct_pkg;

    localparam int ID_W  = 8;
    localparam int REM_W = 31;
    localparam int TICKS_W = 32;

    localparam logic CMD_SLEEP = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic KIND_WAKE   = 1'b0;
    localparam logic KIND_REJECT = 1'b1;

    typedef struct packed {
        logic                      cmd;
        logic [ID_W-1:0]           requester_id;
        logic signed [TICKS_W-1:0] sleep_ticks;
    } t_cmd_item;

    typedef struct packed {
        logic            kind;
        logic [ID_W-1:0] woken_id;
        logic            last;
    } t_result_item;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

endpackage

// ===== rtl/core/sct_dec_unit.sv =====
// sleep countdown table: shared countdown unit, one slot per use
// decides whether an entry wakes and gives its decremented count; uses sct_pkg
module sct_dec_unit (
    input  logic [sct_pkg::REM_W-1:0] i_rem,
    output logic                      o_wake,
    output logic [sct_pkg::REM_W-1:0] o_rem_dec
);
    import sct_pkg::*;

    // a count of one or less expires on this tick
    assign o_wake    = (i_rem <= REM_W'(1));
    assign o_rem_dec = i_rem - REM_W'(1);

endmodule

// ===== rtl/core/sleep_countdown_table_core.sv =====
// sleep countdown table: top level with slot memory and scan sequencer
// uses sct_pkg and sct_dec_unit
//
// usage:
//   an item is taken when start is high and busy is low. a sleep item puts
//   requester_id with its tick count at the front of the table; a tick item
//   counts every entry down by one and wakes those that expire.
//   results leave on o_result, one per cycle, marked by o_strobe; the
//   receiver cannot stall them and must take each on its strobe cycle.
// sleep and tick behaviour:
//   sleep: busy stays low; a rejection (table full)
//   appears on the cycle after the item is taken.
//   tick: busy while the scan runs over the sleeping entries; the
//   single countdown unit visits one slot per cycle through the registered
//   memory read port. wakes come out newest first while the scan runs; the
//   final one, with last set, comes in the first cycle with busy low.
//   a tick with an empty table leaves busy low and gives no result.
// reset:
//   synchronous, active low; empties the table. the slot memory is not
//   cleared, entries are tracked by a fill count and a head pointer.
module sleep_countdown_table_core #(
    parameter int SLOTS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  sct_pkg::t_cmd_item    i_cmd,
    output logic                  busy,
    output logic                  o_strobe,
    output sct_pkg::t_result_item o_result
);
    import sct_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [AW:0]   SLOTS_W  = (AW + 1)'(SLOTS);
    localparam logic [CW-1:0] SLOTS_C  = CW'(SLOTS);
    localparam logic [AW-1:0] LAST_ADR = AW'(SLOTS - 1);

    // slot memory, circular with newest entry at r_head
    logic [ID_W-1:0]  mem_owner [SLOTS];
    logic [REM_W-1:0] mem_rem   [SLOTS];

    t_state r_state, n_state;
    logic [AW-1:0]  r_head, n_head;
    logic [CW-1:0]  r_count, n_count;
    logic [CW-1:0]  r_idx, n_idx;
    logic [CW-1:0]  r_wr, n_wr;
    logic           r_rd_vld, n_rd_vld;
    logic           r_pend, n_pend;
    logic [ID_W-1:0] r_pend_id, n_pend_id;
    logic           r_strobe, n_strobe;
    t_result_item   r_result, n_result;
    logic [ID_W-1:0]  r_rd_owner;
    logic [REM_W-1:0] r_rd_rem;

    logic             accept;
    logic             scan_done;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [ID_W-1:0]  wr_owner;
    logic [REM_W-1:0] wr_rem;
    logic [AW-1:0]    rd_addr;
    logic             dec_wake;
    logic [REM_W-1:0] dec_rem;

    // logical position to physical slot
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] pos);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, pos[AW-1:0]};
        if (sum >= SLOTS_W) begin
            return AW'(sum - SLOTS_W);
        end
        return AW'(sum);
    endfunction

    sct_dec_unit u_dec (
        .i_rem     (r_rd_rem),
        .o_wake    (dec_wake),
        .o_rem_dec (dec_rem)
    );

    assign busy      = (r_state != ST_IDLE);
    assign accept    = start && !busy;
    assign scan_done = (r_idx == r_count) && !r_rd_vld;
    assign rd_addr   = phys(r_head, r_idx);
    assign o_strobe  = r_strobe;
    assign o_result  = r_result;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_cmd.cmd == CMD_TICK && r_count != '0) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_idx     = r_idx;
        n_wr      = r_wr;
        n_rd_vld  = 1'b0;
        n_pend    = r_pend;
        n_pend_id = r_pend_id;
        n_strobe  = 1'b0;
        n_result  = r_result;
        wr_en     = 1'b0;
        wr_addr   = r_head;
        wr_owner  = i_cmd.requester_id;
        wr_rem    = i_cmd.sleep_ticks[TICKS_W-1] ? '0 : i_cmd.sleep_ticks[REM_W-1:0];
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_cmd.cmd == CMD_SLEEP) begin
                    if (r_count == SLOTS_C) begin
                        n_strobe          = 1'b1;
                        n_result.kind     = KIND_REJECT;
                        n_result.woken_id = i_cmd.requester_id;
                        n_result.last     = 1'b1;
                    end else begin
                        // new entry goes in front of the current newest
                        n_head  = (r_head == '0) ? LAST_ADR : r_head - AW'(1);
                        wr_en   = 1'b1;
                        wr_addr = n_head;
                        n_count = r_count + CW'(1);
                    end
                end else if (accept) begin
                    n_idx  = '0;
                    n_wr   = '0;
                    n_pend = 1'b0;
                end
            end
            ST_SCAN: begin
                if (r_idx != r_count) begin
                    n_rd_vld = 1'b1;
                    n_idx    = r_idx + CW'(1);
                end
                if (r_rd_vld) begin
                    if (dec_wake) begin
                        // hold each wake until we know whether another follows
                        if (r_pend) begin
                            n_strobe          = 1'b1;
                            n_result.kind     = KIND_WAKE;
                            n_result.woken_id = r_pend_id;
                            n_result.last     = 1'b0;
                        end
                        n_pend    = 1'b1;
                        n_pend_id = r_rd_owner;
                    end else begin
                        // survivors compact toward the front
                        wr_en    = 1'b1;
                        wr_addr  = phys(r_head, r_wr);
                        wr_owner = r_rd_owner;
                        wr_rem   = dec_rem;
                        n_wr     = r_wr + CW'(1);
                    end
                end
                if (scan_done) begin
                    if (r_pend) begin
                        n_strobe          = 1'b1;
                        n_result.kind     = KIND_WAKE;
                        n_result.woken_id = r_pend_id;
                        n_result.last     = 1'b1;
                    end
                    n_pend  = 1'b0;
                    n_count = r_wr;
                end
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_owner[wr_addr] <= wr_owner;
            mem_rem[wr_addr]   <= wr_rem;
        end
        r_rd_owner <= mem_owner[rd_addr];
        r_rd_rem   <= mem_rem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_idx    <= '0;
            r_wr     <= '0;
            r_rd_vld <= 1'b0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_wr     <= n_wr;
            r_rd_vld <= n_rd_vld;
            r_pend   <= n_pend;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_id <= n_pend_id;
        r_result  <= n_result;
    end

endmodule
